@@ hw/rtl/tlba_pkg.sv @@
// Package for the two-level bitmap block allocator.
// Holds sizes, operation and status codes, the summary update struct and
// bit-search helpers; depends on nothing.
package tlba_pkg;

	localparam int WORD_BITS     = 32;
	localparam int BITMAP_WORDS  = 128;
	localparam int SUMMARY_WORDS = 4;

	localparam int TOTAL_BLOCKS = BITMAP_WORDS * WORD_BITS;
	localparam int BIT_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int WIDX_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int SW_W   = (SUMMARY_WORDS > 1) ? $clog2(SUMMARY_WORDS) : 1;
	localparam int SUM_BITS = SUMMARY_WORDS * WORD_BITS;

	localparam int OP_W  = 3;
	localparam int BLK_W = 12;
	localparam int WI_W  = 7;
	localparam int WV_W  = 32;
	localparam int ST_W  = 2;

	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
	localparam logic [OP_W-1:0] OP_FORMAT  = 3'd2;
	localparam logic [OP_W-1:0] OP_LOAD    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;

	localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [ST_W-1:0] STATUS_NONE  = 2'd1;
	localparam logic [ST_W-1:0] STATUS_RANGE = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WIDX_W-1:0]    widx_t;
	typedef logic [BIT_W-1:0]     bitpos_t;

	typedef struct packed {
		logic  fmt;
		logic  wr;
		widx_t idx;
		logic  on;
	} sum_upd_t;

	function automatic bitpos_t lowest_one(input word_t v);
		word_t   x;
		bitpos_t k;
		int      half;
		x = v;
		k = '0;
		for (int s = BIT_W - 1; s >= 0; s--) begin
			half = 1 << s;
			if ((x & (word_t'({WORD_BITS{1'b1}}) >> (WORD_BITS - half))) == '0) begin
				k[s] = 1'b1;
				x = x >> half;
			end
		end
		return k;
	endfunction

	function automatic word_t summary_mask(input int s);
		word_t m;
		m = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (s * WORD_BITS + j < BITMAP_WORDS) begin
				m[j] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

@@ hw/rtl/two_level_bitmap_block_allocator.sv @@
// Top level of the two-level bitmap block allocator.
// Depends on tlba_pkg, tlba_ram and tlba_summary.
//
// Each transaction passes through S_IDLE, S_MOD and S_DONE: the bitmap RAM is
// read in the accept cycle, the word is modified and written back in S_MOD,
// and in S_DONE the result is moved to the output register once that register
// is free; there it may wait for out_ready while the next transaction is
// accepted. The bitmap RAM has a registered read. Words never written since
// reset or format read as all free through per-word valid bits, so reset and
// format take effect at once with no clearing pass.
module two_level_bitmap_block_allocator import tlba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  operation,
	input  logic [BLK_W-1:0] block_number,
	input  logic [WI_W-1:0]  word_index,
	input  logic [WV_W-1:0]  word_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ST_W-1:0]  status,
	output logic [BLK_W-1:0] granted_block,
	output logic [WV_W-1:0]  read_value
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]       state_q;
	logic             vld_q [BITMAP_WORDS];

	logic [OP_W-1:0]  op_s1;
	widx_t            idx_s1;
	bitpos_t          bit_s1;
	word_t            wval_s1;
	logic             found_s1;
	logic             range_s1;

	logic [ST_W-1:0]  res_status_q;
	logic [BLK_W-1:0] res_granted_q;
	logic [WV_W-1:0]  res_read_q;

	logic             out_valid_q;
	logic [ST_W-1:0]  status_q;
	logic [BLK_W-1:0] granted_q;
	logic [WV_W-1:0]  read_q;

	logic             accept;
	widx_t            idx_in;
	logic             range_in;
	logic             enc_found;
	widx_t            enc_first;
	word_t            rdata;
	word_t            cur;
	word_t            wdata;
	logic             mem_we;
	bitpos_t          low_bit;
	sum_upd_t         sum_upd;
	logic [ST_W-1:0]  nxt_status;
	logic [BLK_W-1:0] nxt_granted;
	logic [WV_W-1:0]  nxt_read;
	logic             out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (operation)
			OP_ALLOC: begin
				idx_in   = enc_first;
				range_in = 1'b0;
			end
			OP_RELEASE: begin
				idx_in   = WIDX_W'(int'(block_number) / WORD_BITS);
				range_in = int'(block_number) >= TOTAL_BLOCKS;
			end
			default: begin
				idx_in   = WIDX_W'(word_index);
				range_in = int'(word_index) >= BITMAP_WORDS;
			end
		endcase
	end

	tlba_summary u_summary (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (sum_upd),
		.found      (enc_found),
		.first_word (enc_first)
	);

	tlba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (BITMAP_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (idx_in),
		.rdata (rdata)
	);

	assign cur     = vld_q[idx_s1] ? rdata : '1;
	assign low_bit = lowest_one(cur);

	always_comb begin
		mem_we      = 1'b0;
		wdata       = cur;
		sum_upd     = '0;
		sum_upd.idx = idx_s1;
		nxt_status  = STATUS_OK;
		nxt_granted = '0;
		nxt_read    = '0;
		if (state_q == S_MOD) begin
			case (op_s1)
				OP_ALLOC: begin
					if (found_s1) begin
						wdata        = cur & ~(word_t'(1) << low_bit);
						mem_we       = 1'b1;
						sum_upd.wr   = 1'b1;
						sum_upd.on   = (wdata != '0);
						nxt_granted  = BLK_W'(int'(idx_s1) * WORD_BITS + int'(low_bit));
					end else begin
						nxt_status = STATUS_NONE;
					end
				end
				OP_RELEASE: begin
					if (range_s1) begin
						nxt_status = STATUS_RANGE;
					end else begin
						wdata      = cur | (word_t'(1) << bit_s1);
						mem_we     = 1'b1;
						sum_upd.wr = 1'b1;
						sum_upd.on = 1'b1;
					end
				end
				OP_FORMAT: begin
					sum_upd.fmt = 1'b1;
				end
				OP_LOAD: begin
					if (range_s1) begin
						nxt_status = STATUS_RANGE;
					end else begin
						wdata      = wval_s1;
						mem_we     = 1'b1;
						sum_upd.wr = 1'b1;
						sum_upd.on = (wval_s1 != '0);
					end
				end
				OP_READ: begin
					if (range_s1) begin
						nxt_status = STATUS_RANGE;
					end else begin
						nxt_read = WV_W'(cur);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BITMAP_WORDS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (sum_upd.fmt) begin
			for (int i = 0; i < BITMAP_WORDS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (mem_we) begin
			vld_q[idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			idx_s1   <= idx_in;
			bit_s1   <= BIT_W'(int'(block_number) % WORD_BITS);
			wval_s1  <= word_t'(word_value);
			found_s1 <= enc_found;
			range_s1 <= range_in;
		end
		if (state_q == S_MOD) begin
			res_status_q  <= nxt_status;
			res_granted_q <= nxt_granted;
			res_read_q    <= nxt_read;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q  <= res_status_q;
			granted_q <= res_granted_q;
			read_q    <= res_read_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_block = granted_q;
	assign read_value    = read_q;

endmodule

@@ hw/rtl/tlba_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
module tlba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/tlba_summary.sv @@
// Summary bitmap: one bit per bitmap word, plus a registered search for the
// lowest word that still has a free block. Depends on tlba_pkg.
module tlba_summary import tlba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sum_upd_t upd,
	output logic     found,
	output widx_t    first_word
);

	word_t   sum_q [SUMMARY_WORDS];
	logic    found_q;
	widx_t   first_q;
	logic    found_d;
	widx_t   first_d;
	logic [SW_W-1:0] sw;
	bitpos_t sb;

	assign sw = SW_W'(int'(upd.idx) / WORD_BITS);
	assign sb = BIT_W'(int'(upd.idx) % WORD_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SUMMARY_WORDS; s++) begin
				sum_q[s] <= '1;
			end
		end else if (upd.fmt) begin
			for (int s = 0; s < SUMMARY_WORDS; s++) begin
				sum_q[s] <= '1;
			end
		end else if (upd.wr && int'(upd.idx) < SUM_BITS) begin
			sum_q[sw][sb] <= upd.on;
		end
	end

	always_comb begin
		word_t m;
		found_d = 1'b0;
		first_d = '0;
		for (int s = SUMMARY_WORDS - 1; s >= 0; s--) begin
			m = sum_q[s] & summary_mask(s);
			if (m != '0) begin
				found_d = 1'b1;
				first_d = WIDX_W'(s * WORD_BITS + int'(lowest_one(m)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b1;
			first_q <= '0;
		end else begin
			found_q <= found_d;
			first_q <= first_d;
		end
	end

	assign found      = found_q;
	assign first_word = first_q;

endmodule
